// File: sv/eig2_pkg.sv
`timescale 1ns / 1ps

package eig2_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int VEC_W          = 16;
    localparam int VEC_FRAC       = 14;
    localparam int VEC_ONE        = 16384;
    localparam int NORM_W         = 30;

endpackage

// File: sv/eig2_sqrt_pipe.sv
`timescale 1ns / 1ps

// Pipelined integer square root: one result bit is settled per stage.
module eig2_sqrt_pipe #(
    parameter int RAD_W  = 66,
    parameter int ROOT_W = 33,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int TW = 2 * ROOT_W + 1;

    logic [TW-1:0]     rem_st  [ROOT_W+1];
    logic [ROOT_W-1:0] root_st [ROOT_W+1];
    logic [SIDE_W-1:0] side_st [ROOT_W+1];
    logic              vld_st  [ROOT_W+1];

    assign rem_st[0]  = TW'(rad);
    assign root_st[0] = '0;
    assign side_st[0] = in_side;
    assign vld_st[0]  = in_valid;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_st
        localparam int B = ROOT_W - 1 - k;
        logic [TW-1:0]     trial;
        logic              take;
        logic              vld_reg;
        logic [TW-1:0]     rem_reg;
        logic [ROOT_W-1:0] root_reg;
        logic [SIDE_W-1:0] side_reg;

        assign trial = (TW'(root_st[k]) << (B + 1)) | (TW'(1) << (2 * B));
        assign take  = rem_st[k] >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (en) begin
                vld_reg <= vld_st[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg  <= take ? rem_st[k] - trial : rem_st[k];
                root_reg <= take ? (root_st[k] | (ROOT_W'(1) << B)) : root_st[k];
                side_reg <= side_st[k];
            end
        end

        assign rem_st[k+1]  = rem_reg;
        assign root_st[k+1] = root_reg;
        assign side_st[k+1] = side_reg;
        assign vld_st[k+1]  = vld_reg;
    end

    assign out_valid = vld_st[ROOT_W];
    assign root      = root_st[ROOT_W];
    assign out_side  = side_st[ROOT_W];

endmodule

// File: sv/eig2_div_pipe.sv
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage. The quotient must fit in Q_W bits.
module eig2_div_pipe #(
    parameter int NUM_W  = 45,
    parameter int DEN_W  = 31,
    parameter int Q_W    = 16,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    quo,
    output logic [SIDE_W-1:0] out_side
);

    localparam int TW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [TW-1:0]     rem_st  [Q_W+1];
    logic [DEN_W-1:0]  den_st  [Q_W+1];
    logic [Q_W-1:0]    quo_st  [Q_W+1];
    logic [SIDE_W-1:0] side_st [Q_W+1];
    logic              vld_st  [Q_W+1];

    assign rem_st[0]  = TW'(num);
    assign den_st[0]  = den;
    assign quo_st[0]  = '0;
    assign side_st[0] = in_side;
    assign vld_st[0]  = in_valid;

    for (genvar k = 0; k < Q_W; k++) begin : g_st
        localparam int B = Q_W - 1 - k;
        logic [TW-1:0]     trial;
        logic              take;
        logic              vld_reg;
        logic [TW-1:0]     rem_reg;
        logic [DEN_W-1:0]  den_reg;
        logic [Q_W-1:0]    quo_reg;
        logic [SIDE_W-1:0] side_reg;

        assign trial = TW'(den_st[k]) << B;
        assign take  = rem_st[k] >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (en) begin
                vld_reg <= vld_st[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg  <= take ? rem_st[k] - trial : rem_st[k];
                den_reg  <= den_st[k];
                quo_reg  <= take ? (quo_st[k] | (Q_W'(1) << B)) : quo_st[k];
                side_reg <= side_st[k];
            end
        end

        assign rem_st[k+1]  = rem_reg;
        assign den_st[k+1]  = den_reg;
        assign quo_st[k+1]  = quo_reg;
        assign side_st[k+1] = side_reg;
        assign vld_st[k+1]  = vld_reg;
    end

    assign out_valid = vld_st[Q_W];
    assign quo       = quo_st[Q_W];
    assign out_side  = side_st[Q_W];

endmodule

// File: sv/eig2_unit_vec.sv
`timescale 1ns / 1ps

// Normalises (vx, vy) to a Q2.14 unit vector through a pipelined root and two dividers.
module eig2_unit_vec
    import eig2_pkg::*;
#(
    parameter int VX_W   = 35,
    parameter int VY_W   = 32,
    parameter int SIDE_W = 1,
    parameter bit FIRST  = 1'b1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [VX_W-1:0]  vx,
    input  logic signed [VY_W-1:0]  vy,
    input  logic [SIDE_W-1:0]       in_side,
    output logic                    out_valid,
    output logic signed [VEC_W-1:0] ox,
    output logic signed [VEC_W-1:0] oy,
    output logic [SIDE_W-1:0]       out_side
);

    localparam int AW     = (VX_W > VY_W) ? VX_W : VY_W;
    localparam int EW     = (AW > NORM_W) ? AW : NORM_W;
    localparam int SH_W   = $clog2(EW + 1);
    localparam int SQ_W   = 2 * NORM_W;
    localparam int RAD_W  = SQ_W + 1;
    localparam int ROOT_W = NORM_W + 1;
    localparam int NUM_W  = NORM_W + VEC_FRAC + 1;
    localparam int SQ_SIDE_W = SIDE_W + 2 + 2 * NORM_W;
    localparam int DX_SIDE_W = SIDE_W + 2;

    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic [EW-1:0]     ax1_reg, ay1_reg, ax2_reg, ay2_reg;
    logic [1:0]        neg1_reg, neg2_reg, neg3_reg, neg4_reg, neg5_reg;
    logic [SIDE_W-1:0] side1_reg, side2_reg, side3_reg, side4_reg, side5_reg, side6_reg;
    logic [SIDE_W-1:0] side7_reg;
    logic [SH_W-1:0]   sh_next, sh2_reg;
    logic [NORM_W-1:0] ax3_reg, ay3_reg, ax4_reg, ay4_reg, ax5_reg, ay5_reg;
    logic [SQ_W-1:0]   sqx4_reg, sqy4_reg;
    logic [RAD_W-1:0]  rad5_reg;
    logic [EW-1:0]     ao;
    logic [SH_W-1:0]   len;

    logic                 sq_valid;
    logic [ROOT_W-1:0]    r;
    logic [SQ_SIDE_W-1:0] sq_side;
    logic [NORM_W-1:0]    sq_ax, sq_ay;
    logic [1:0]           sq_neg;
    logic [SIDE_W-1:0]    sq_user;

    logic [NUM_W-1:0]  nx6_reg, ny6_reg;
    logic [ROOT_W-1:0] r6_reg;
    logic              rz6_reg;
    logic [1:0]        neg6_reg;

    logic                 dx_valid, dy_valid;
    logic [VEC_W-1:0]     qx, qy, cx, cy;
    logic [DX_SIDE_W-1:0] dx_side;
    logic                 dy_side;
    logic signed [VEC_W-1:0] ox_next, oy_next, ox7_reg, oy7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= sq_valid;
            v7_reg <= dx_valid & dy_valid;
        end
    end

    always_comb begin
        ao  = ax1_reg | ay1_reg;
        len = '0;
        for (int i = 0; i < EW; i++) begin
            if (ao[i]) begin
                len = SH_W'(i + 1);
            end
        end
        sh_next = (len > SH_W'(NORM_W)) ? len - SH_W'(NORM_W) : '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax1_reg   <= EW'($unsigned(vx[VX_W-1] ? VX_W'(-vx) : VX_W'(vx)));
            ay1_reg   <= EW'($unsigned(vy[VY_W-1] ? VY_W'(-vy) : VY_W'(vy)));
            neg1_reg  <= {vx[VX_W-1], vy[VY_W-1]};
            side1_reg <= in_side;

            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            sh2_reg   <= sh_next;
            neg2_reg  <= neg1_reg;
            side2_reg <= side1_reg;

            ax3_reg   <= NORM_W'(ax2_reg >> sh2_reg);
            ay3_reg   <= NORM_W'(ay2_reg >> sh2_reg);
            neg3_reg  <= neg2_reg;
            side3_reg <= side2_reg;

            sqx4_reg  <= SQ_W'(ax3_reg) * SQ_W'(ax3_reg);
            sqy4_reg  <= SQ_W'(ay3_reg) * SQ_W'(ay3_reg);
            ax4_reg   <= ax3_reg;
            ay4_reg   <= ay3_reg;
            neg4_reg  <= neg3_reg;
            side4_reg <= side3_reg;

            rad5_reg  <= RAD_W'(sqx4_reg) + RAD_W'(sqy4_reg);
            ax5_reg   <= ax4_reg;
            ay5_reg   <= ay4_reg;
            neg5_reg  <= neg4_reg;
            side5_reg <= side4_reg;
        end
    end

    eig2_sqrt_pipe #(
        .RAD_W  (RAD_W),
        .ROOT_W (ROOT_W),
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5_reg),
        .rad       (rad5_reg),
        .in_side   ({side5_reg, neg5_reg, ax5_reg, ay5_reg}),
        .out_valid (sq_valid),
        .root      (r),
        .out_side  (sq_side)
    );

    assign {sq_user, sq_neg, sq_ax, sq_ay} = sq_side;

    always_ff @(posedge aclk) begin
        if (en) begin
            nx6_reg   <= (NUM_W'(sq_ax) << VEC_FRAC) + NUM_W'(r >> 1);
            ny6_reg   <= (NUM_W'(sq_ay) << VEC_FRAC) + NUM_W'(r >> 1);
            r6_reg    <= r;
            rz6_reg   <= (r == '0);
            neg6_reg  <= sq_neg;
            side6_reg <= sq_user;
        end
    end

    eig2_div_pipe #(
        .NUM_W  (NUM_W),
        .DEN_W  (ROOT_W),
        .Q_W    (VEC_W),
        .SIDE_W (DX_SIDE_W)
    ) u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v6_reg),
        .num       (nx6_reg),
        .den       (r6_reg),
        .in_side   ({side6_reg, neg6_reg[1], rz6_reg}),
        .out_valid (dx_valid),
        .quo       (qx),
        .out_side  (dx_side)
    );

    eig2_div_pipe #(
        .NUM_W  (NUM_W),
        .DEN_W  (ROOT_W),
        .Q_W    (VEC_W),
        .SIDE_W (1)
    ) u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v6_reg),
        .num       (ny6_reg),
        .den       (r6_reg),
        .in_side   (neg6_reg[0]),
        .out_valid (dy_valid),
        .quo       (qy),
        .out_side  (dy_side)
    );

    always_comb begin
        cx = (qx > VEC_W'(VEC_ONE)) ? VEC_W'(VEC_ONE) : qx;
        cy = (qy > VEC_W'(VEC_ONE)) ? VEC_W'(VEC_ONE) : qy;
        if (dx_side[0]) begin
            ox_next = FIRST ? VEC_W'(VEC_ONE) : '0;
            oy_next = FIRST ? '0 : VEC_W'(VEC_ONE);
        end else begin
            ox_next = dx_side[1] ? -$signed(cx) : $signed(cx);
            oy_next = dy_side ? -$signed(cy) : $signed(cy);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ox7_reg   <= ox_next;
            oy7_reg   <= oy_next;
            side7_reg <= dx_side[DX_SIDE_W-1:2];
        end
    end

    assign out_valid = v7_reg;
    assign ox        = ox7_reg;
    assign oy        = oy7_reg;
    assign out_side  = side7_reg;

endmodule

// File: sv/eigen2x2_symmetric_sorted_core.sv
`timescale 1ns / 1ps

// Eigendecomposition of one symmetric 2x2 Hessian per transfer: two eigenvalues in signed
// Q18.16 and their unit eigenvectors in Q2.14, ordered so that the value of larger magnitude
// comes first. The block takes one transfer every cycle while the output is not stalled. It is
// built from the one-bit-per-stage square root of the discriminant, the 31-stage root of the
// vector length and the 16-stage quotient pipelines. The whole pipeline holds while a result
// waits at the output.
module eigen2x2_symmetric_sorted_core
    import eig2_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // hess_xx, hess_xy, hess_yy from the lowest bit up, zero padded to whole bytes.
    input  logic [((3*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic s_tlast,
    output logic m_tvalid,
    input  logic m_tready,
    // major_value, major_vx, major_vy, minor_value, minor_vx, minor_vy from the lowest bit up.
    output logic [((2*(DATA_WIDTH+2)+4*VEC_W+7)/8)*8-1:0] m_tdata,
    output logic m_tlast
);

    localparam int DW      = DATA_WIDTH;
    localparam int VW      = DW + 2;
    localparam int OUT_W   = ((2 * VW + 4 * VEC_W + 7) / 8) * 8;
    localparam int LO      = (DW + 2) / 2;
    localparam int HI_W    = DW + 1 - LO;
    localparam int SQ_W    = 2 * DW + 2;
    localparam int ROOT_W  = DW + 1;
    localparam int SQ_SIDE = 3 * DW + 3;
    localparam int U1_SIDE = VW + 3;

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, e1_reg, e2_reg;

    logic signed [DW-1:0] xx, xy, yy;
    logic signed [DW:0]   d1_reg, t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic signed [DW-1:0] xy1_reg, xy2_reg, xy3_reg, xy4_reg, xy5_reg;
    logic signed [DW-1:0] yy1_reg, yy2_reg, yy3_reg, yy4_reg, yy5_reg;
    logic [1:0]           f1_reg, f2_reg, f3_reg, f4_reg, f5_reg;
    logic [DW:0]          ad2_reg, axy2_reg;
    logic [2*HI_W-1:0]    dhh_reg, xhh_reg;
    logic [HI_W+LO-1:0]   dhl_reg, xhl_reg;
    logic [2*LO-1:0]      dll_reg, xll_reg;
    logic [SQ_W-1:0]      sqd4_reg, sqx4_reg, rad5_reg;

    logic                 sq_valid;
    logic [ROOT_W-1:0]    disc;
    logic [SQ_SIDE-1:0]   sq_side;
    logic signed [DW:0]   sq_t;
    logic signed [DW-1:0] sq_yy, sq_xy;
    logic [1:0]           sq_f;
    logic signed [DW+2:0] h1, h2;
    logic signed [VW-1:0] l1_next, l2_next;

    logic signed [VW-1:0] l1_e1_reg, l2_e1_reg, l1_e2_reg, l2_e2_reg;
    logic signed [DW-1:0] yy_e1_reg, xy_e1_reg, xy_e2_reg;
    logic [1:0]           f_e1_reg, f_e2_reg;
    logic                 xyz_e2_reg;
    logic signed [VW:0]   v1_e2_reg, v2_e2_reg;

    logic                    u1_valid, u2_valid;
    logic signed [VEC_W-1:0] u1x, u1y, u2x, u2y;
    logic [U1_SIDE-1:0]      u1_side;
    logic [VW-1:0]           u2_side;
    logic signed [VW-1:0]    fl1, fl2;
    logic                    f_fe, f_xyz, f_gt;
    logic signed [VEC_W-1:0] a1x, a1y, a2x, a2y;
    logic [VW-1:0]           m1, m2;
    logic                    first_major;

    logic                    m_valid_reg;
    logic                    m_last_reg;
    logic signed [VW-1:0]    mj_val_reg, mn_val_reg;
    logic signed [VEC_W-1:0] mj_x_reg, mj_y_reg, mn_x_reg, mn_y_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    assign xx = $signed(s_tdata[DW-1:0]);
    assign xy = $signed(s_tdata[2*DW-1:DW]);
    assign yy = $signed(s_tdata[3*DW-1:2*DW]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            e1_reg <= 1'b0;
            e2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            e1_reg <= sq_valid;
            e2_reg <= e1_reg;
        end
    end

    // Front end: difference and trace, magnitudes, split squares, then the radicand.
    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg  <= $signed({xx[DW-1], xx}) - $signed({yy[DW-1], yy});
            t1_reg  <= $signed({xx[DW-1], xx}) + $signed({yy[DW-1], yy});
            xy1_reg <= xy;
            yy1_reg <= yy;
            f1_reg  <= {xx > yy, s_tlast};

            ad2_reg  <= d1_reg[DW] ? (DW+1)'(-d1_reg) : (DW+1)'(d1_reg);
            axy2_reg <= (DW+1)'($unsigned(xy1_reg[DW-1] ? DW'(-xy1_reg) : DW'(xy1_reg)));
            t2_reg   <= t1_reg;
            xy2_reg  <= xy1_reg;
            yy2_reg  <= yy1_reg;
            f2_reg   <= f1_reg;

            dhh_reg <= (2*HI_W)'(ad2_reg[DW:LO]) * (2*HI_W)'(ad2_reg[DW:LO]);
            dhl_reg <= (HI_W+LO)'(ad2_reg[DW:LO]) * (HI_W+LO)'(ad2_reg[LO-1:0]);
            dll_reg <= (2*LO)'(ad2_reg[LO-1:0]) * (2*LO)'(ad2_reg[LO-1:0]);
            xhh_reg <= (2*HI_W)'(axy2_reg[DW:LO]) * (2*HI_W)'(axy2_reg[DW:LO]);
            xhl_reg <= (HI_W+LO)'(axy2_reg[DW:LO]) * (HI_W+LO)'(axy2_reg[LO-1:0]);
            xll_reg <= (2*LO)'(axy2_reg[LO-1:0]) * (2*LO)'(axy2_reg[LO-1:0]);
            t3_reg  <= t2_reg;
            xy3_reg <= xy2_reg;
            yy3_reg <= yy2_reg;
            f3_reg  <= f2_reg;

            sqd4_reg <= (SQ_W'(dhh_reg) << (2 * LO)) + (SQ_W'(dhl_reg) << (LO + 1))
                        + SQ_W'(dll_reg);
            sqx4_reg <= (SQ_W'(xhh_reg) << (2 * LO)) + (SQ_W'(xhl_reg) << (LO + 1))
                        + SQ_W'(xll_reg);
            t4_reg   <= t3_reg;
            xy4_reg  <= xy3_reg;
            yy4_reg  <= yy3_reg;
            f4_reg   <= f3_reg;

            rad5_reg <= sqd4_reg + (sqx4_reg << 2);
            t5_reg   <= t4_reg;
            xy5_reg  <= xy4_reg;
            yy5_reg  <= yy4_reg;
            f5_reg   <= f4_reg;
        end
    end

    eig2_sqrt_pipe #(
        .RAD_W  (SQ_W),
        .ROOT_W (ROOT_W),
        .SIDE_W (SQ_SIDE)
    ) u_disc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5_reg),
        .rad       (rad5_reg),
        .in_side   ({t5_reg, yy5_reg, xy5_reg, f5_reg}),
        .out_valid (sq_valid),
        .root      (disc),
        .out_side  (sq_side)
    );

    assign {sq_t, sq_yy, sq_xy, sq_f} = sq_side;

    always_comb begin
        h1 = ($signed({{2{sq_t[DW]}}, sq_t}) + $signed({2'b00, disc})) >>> 1;
        h2 = ($signed({{2{sq_t[DW]}}, sq_t}) - $signed({2'b00, disc})) >>> 1;
        if (h1[DW+2] != h1[DW+1]) begin
            l1_next = h1[DW+2] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end else begin
            l1_next = h1[VW-1:0];
        end
        if (h2[DW+2] != h2[DW+1]) begin
            l2_next = h2[DW+2] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end else begin
            l2_next = h2[VW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l1_e1_reg <= l1_next;
            l2_e1_reg <= l2_next;
            yy_e1_reg <= sq_yy;
            xy_e1_reg <= sq_xy;
            f_e1_reg  <= sq_f;

            v1_e2_reg  <= $signed({l1_e1_reg[VW-1], l1_e1_reg})
                          - $signed({{3{yy_e1_reg[DW-1]}}, yy_e1_reg});
            v2_e2_reg  <= $signed({l2_e1_reg[VW-1], l2_e1_reg})
                          - $signed({{3{yy_e1_reg[DW-1]}}, yy_e1_reg});
            l1_e2_reg  <= l1_e1_reg;
            l2_e2_reg  <= l2_e1_reg;
            xy_e2_reg  <= xy_e1_reg;
            xyz_e2_reg <= (xy_e1_reg == '0);
            f_e2_reg   <= f_e1_reg;
        end
    end

    eig2_unit_vec #(
        .VX_W   (VW + 1),
        .VY_W   (DW),
        .SIDE_W (U1_SIDE),
        .FIRST  (1'b1)
    ) u_vec1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (e2_reg),
        .vx        (v1_e2_reg),
        .vy        (xy_e2_reg),
        .in_side   ({l1_e2_reg, f_e2_reg[0], xyz_e2_reg, f_e2_reg[1]}),
        .out_valid (u1_valid),
        .ox        (u1x),
        .oy        (u1y),
        .out_side  (u1_side)
    );

    eig2_unit_vec #(
        .VX_W   (VW + 1),
        .VY_W   (DW),
        .SIDE_W (VW),
        .FIRST  (1'b0)
    ) u_vec2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (e2_reg),
        .vx        (v2_e2_reg),
        .vy        (xy_e2_reg),
        .in_side   (l2_e2_reg),
        .out_valid (u2_valid),
        .ox        (u2x),
        .oy        (u2y),
        .out_side  (u2_side)
    );

    // A zero off-diagonal gives axis-aligned vectors; the pair is then ordered by magnitude.
    always_comb begin
        {fl1, f_fe, f_xyz, f_gt} = u1_side;
        fl2 = $signed(u2_side);
        if (f_xyz) begin
            a1x = f_gt ? VEC_W'(VEC_ONE) : '0;
            a1y = f_gt ? '0 : VEC_W'(VEC_ONE);
            a2x = f_gt ? '0 : VEC_W'(VEC_ONE);
            a2y = f_gt ? VEC_W'(VEC_ONE) : '0;
        end else begin
            a1x = u1x;
            a1y = u1y;
            a2x = u2x;
            a2y = u2y;
        end
        m1 = fl1[VW-1] ? VW'(-fl1) : VW'(fl1);
        m2 = fl2[VW-1] ? VW'(-fl2) : VW'(fl2);
        first_major = m1 >= m2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= u1_valid & u2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_last_reg <= f_fe;
            mj_val_reg <= first_major ? fl1 : fl2;
            mj_x_reg   <= first_major ? a1x : a2x;
            mj_y_reg   <= first_major ? a1y : a2y;
            mn_val_reg <= first_major ? fl2 : fl1;
            mn_x_reg   <= first_major ? a2x : a1x;
            mn_y_reg   <= first_major ? a2y : a1y;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = OUT_W'({mn_y_reg, mn_x_reg, mn_val_reg, mj_y_reg, mj_x_reg, mj_val_reg});

endmodule

// File: sv/eig2_checker.sv
`timescale 1ns / 1ps

module eig2_checker
    import eig2_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic aclk,
    input logic aresetn,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((2*(DATA_WIDTH+2)+4*VEC_W+7)/8)*8-1:0] m_tdata,
    input logic m_tlast
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result transfer offered straight after reset");

    // An empty output register never holds back the input side.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

    // A downstream that takes results keeps the input side flowing.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while results drain");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result transfer changed");

endmodule

bind eigen2x2_symmetric_sorted_core eig2_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_eig2_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import eig2_pkg::*;

    localparam int DW      = 32;
    localparam int VW      = DW + 2;
    localparam int SW      = ((3 * DW + 7) / 8) * 8;
    localparam int MW      = ((2 * VW + 4 * VEC_W + 7) / 8) * 8;
    localparam int LATENCY = DW + 63;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic          frame_end;
        logic [DW-1:0] yy;
        logic [DW-1:0] xy;
        logic [DW-1:0] xx;
    } hessian_t;

    typedef struct packed {
        logic [VW-1:0]    major_value;
        logic [VEC_W-1:0] major_vx;
        logic [VEC_W-1:0] major_vy;
        logic [VW-1:0]    minor_value;
        logic [VEC_W-1:0] minor_vx;
        logic [VEC_W-1:0] minor_vy;
        logic             frame_end;
    } eigen_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SW-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [MW-1:0] m_tdata;
    logic m_tlast;

    hessian_t pixel_queue[$];
    eigen_t   expected_eigen[$];
    int       mismatches = 0;
    int       pixels_sent = 0;
    int       results_seen = 0;
    int       idle_free = 0;
    int       quiet_cycles = 0;
    bit       stimulus_done = 1'b0;

    always #5 aclk = ~aclk;

    eigen2x2_symmetric_sorted_core #(.DATA_WIDTH(DW)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    function automatic logic [127:0] root128(input logic [127:0] v);
        logic [127:0] res;
        logic [127:0] cand;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = res | (128'd1 << b);
            if (cand * cand <= v) res = cand;
        end
        return res;
    endfunction

    function automatic longint halve_floor(input longint v);
        return v >>> 1;
    endfunction

    function automatic longint clamp_value(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (VW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint scale_component(input longint a, input bit neg, input longint r);
        longint q;
        q = (a * VEC_ONE + r / 2) / r;
        if (q > VEC_ONE) q = VEC_ONE;
        return neg ? -q : q;
    endfunction

    task automatic normalise(input longint vx, input longint vy, input bit first,
                             output longint ox, output longint oy);
        longint ax;
        longint ay;
        longint r;
        ax = vx < 0 ? -vx : vx;
        ay = vy < 0 ? -vy : vy;
        while ((ax | ay) >= (longint'(1) <<< NORM_W)) begin
            ax = ax >> 1;
            ay = ay >> 1;
        end
        r = longint'(root128(128'(ax * ax + ay * ay)));
        if (r == 0) begin
            ox = first ? VEC_ONE : 0;
            oy = first ? 0 : VEC_ONE;
        end else begin
            ox = scale_component(ax, vx < 0, r);
            oy = scale_component(ay, vy < 0, r);
        end
    endtask

    task automatic predict_eigen(input hessian_t h, output eigen_t e);
        longint xx;
        longint xy;
        longint yy;
        longint d;
        longint t;
        longint disc;
        longint l1;
        longint l2;
        longint v1x;
        longint v1y;
        longint v2x;
        longint v2y;
        longint m1;
        longint m2;
        logic [127:0] sum;
        xx = longint'($signed(h.xx));
        xy = longint'($signed(h.xy));
        yy = longint'($signed(h.yy));
        d = xx - yy;
        t = xx + yy;
        if (d < 0) d = -d;
        sum = 128'(d) * 128'(d) + 128'd4 * 128'(xy < 0 ? -xy : xy) * 128'(xy < 0 ? -xy : xy);
        disc = longint'(root128(sum));
        l1 = clamp_value(halve_floor(t + disc));
        l2 = clamp_value(halve_floor(t - disc));
        if (xy != 0) begin
            normalise(l1 - yy, xy, 1'b1, v1x, v1y);
            normalise(l2 - yy, xy, 1'b0, v2x, v2y);
        end else if (xx > yy) begin
            v1x = VEC_ONE; v1y = 0; v2x = 0; v2y = VEC_ONE;
        end else begin
            v1x = 0; v1y = VEC_ONE; v2x = VEC_ONE; v2y = 0;
        end
        m1 = l1 < 0 ? -l1 : l1;
        m2 = l2 < 0 ? -l2 : l2;
        if (m1 >= m2) begin
            e.major_value = VW'(l1); e.major_vx = VEC_W'(v1x); e.major_vy = VEC_W'(v1y);
            e.minor_value = VW'(l2); e.minor_vx = VEC_W'(v2x); e.minor_vy = VEC_W'(v2y);
        end else begin
            e.major_value = VW'(l2); e.major_vx = VEC_W'(v2x); e.major_vy = VEC_W'(v2y);
            e.minor_value = VW'(l1); e.minor_vx = VEC_W'(v1x); e.minor_vy = VEC_W'(v1y);
        end
        e.frame_end = h.frame_end;
    endtask

    function automatic logic [DW-1:0] random_entry();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return DW'($signed($urandom_range(0, 8191)) - 4096);
            4: return DW'($signed($urandom_range(0, 33554431)) - 16777216);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_pixel(input logic [DW-1:0] xx, input logic [DW-1:0] xy,
                             input logic [DW-1:0] yy, input logic fe);
        hessian_t h;
        h.xx = xx; h.xy = xy; h.yy = yy; h.frame_end = fe;
        pixel_queue.push_back(h);
    endtask

    initial begin
        logic [DW-1:0] a;
        add_pixel('0, '0, '0, 1'b0);
        add_pixel(32'h0001_0000, '0, 32'h0001_0000, 1'b0);
        add_pixel(32'h0002_0000, '0, 32'h0001_0000, 1'b0);
        add_pixel(32'h0001_0000, '0, 32'h0002_0000, 1'b1);
        add_pixel(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        add_pixel(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        add_pixel(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b0);
        add_pixel(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
        add_pixel(32'h8000_0000, '0, 32'h7fff_ffff, 1'b0);
        add_pixel(32'h7fff_ffff, '0, 32'h8000_0000, 1'b0);
        add_pixel('0, 32'h0001_0000, '0, 1'b0);
        add_pixel('0, 32'hffff_0000, '0, 1'b0);
        add_pixel('0, 32'h0000_0001, '0, 1'b0);
        add_pixel(32'h0003_0000, 32'h0001_0000, 32'hfffd_0000, 1'b0);
        add_pixel(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
        add_pixel(32'h0001_0000, '0, 32'hffff_0000, 1'b0);
        add_pixel(32'hffff_0000, '0, 32'h0001_0000, 1'b0);
        for (int i = 0; i < 1300; i++) begin
            a = random_entry();
            if ($urandom_range(0, 7) == 0)
                add_pixel(a, random_entry(), a, 1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 7) == 0)
                add_pixel(a, '0, random_entry(), 1'($urandom_range(0, 1)));
            else
                add_pixel(random_entry(), random_entry(), random_entry(),
                          1'($urandom_range(0, 1)));
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (idle_free == 0 && pixels_sent == 600) idle_free <= 400;
            else if (idle_free > 0) idle_free <= idle_free - 1;
        end
    end

    always @(posedge aclk) begin
        eigen_t e;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_eigen(hessian_t'({s_tlast, s_tdata[3*DW-1:0]}), e);
                expected_eigen.push_back(e);
                pixels_sent <= pixels_sent + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pixel_queue.size() > 0 && (idle_free > 0 || $urandom_range(0, 99) >= 15)) begin
                    hessian_t h;
                    h = pixel_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= SW'({h.yy, h.xy, h.xx});
                    s_tlast <= h.frame_end;
                end else begin
                    s_tvalid <= 1'b0;
                    if (pixel_queue.size() == 0) stimulus_done <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        eigen_t got;
        eigen_t want;
        if (aresetn) begin
            m_tready <= idle_free > 0 || $urandom_range(0, 99) >= 15;
            if (m_tvalid && m_tready) begin
                got.major_value = m_tdata[VW-1:0];
                got.major_vx    = m_tdata[VW +: VEC_W];
                got.major_vy    = m_tdata[VW+VEC_W +: VEC_W];
                got.minor_value = m_tdata[VW+2*VEC_W +: VW];
                got.minor_vx    = m_tdata[2*VW+2*VEC_W +: VEC_W];
                got.minor_vy    = m_tdata[2*VW+3*VEC_W +: VEC_W];
                got.frame_end   = m_tlast;
                results_seen <= results_seen + 1;
                if (expected_eigen.size() == 0) begin
                    if (mismatches < 10) $display("unexpected result transfer %h", got);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_eigen.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("mismatch: expected %h %h %h %h %h %h %b",
                                     want.major_value, want.major_vx, want.major_vy,
                                     want.minor_value, want.minor_vx, want.minor_vy,
                                     want.frame_end);
                            $display("          actual   %h %h %h %h %h %h %b",
                                     got.major_value, got.major_vx, got.major_vy,
                                     got.minor_value, got.minor_vx, got.minor_vy,
                                     got.frame_end);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (aresetn);
        while (!(stimulus_done && !s_tvalid && expected_eigen.size() == 0)) begin
            @(posedge aclk);
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
        repeat (2 * LATENCY) @(posedge aclk);
        $display("Sent %0d Hessian pixels with random stalls on both channels,", pixels_sent);
        $display("checked %0d eigen results, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && expected_eigen.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: eigen2x2_symmetric_sorted_core.f
sv/eig2_pkg.sv
sv/eig2_sqrt_pipe.sv
sv/eig2_div_pipe.sv
sv/eig2_unit_vec.sv
sv/eigen2x2_symmetric_sorted_core.sv
sv/eig2_checker.sv
test/tb_top.sv
